// ===== sv/kdq_pkg.sv =====
// kdq_pkg: shared types and constants for the keyed deque with removal.
// Holds the operation codes, the controller states and the stored entry and result layouts.
// No dependencies.
`default_nettype none

package kdq_pkg;

	localparam int KEY_W     = 64;
	localparam int PAY_W     = 64;
	localparam int OCC_W     = 8;
	localparam int KIND_W    = 2;
	localparam int IN_DATA_W = 128;
	localparam int OUT_DATA_W = 144;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH_TAIL = 2'd0,
		KIND_PUSH_HEAD = 2'd1,
		KIND_POP_HEAD  = 2'd2,
		KIND_DELETE    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_SCAN,
		ST_SHIFT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [PAY_W-1:0] payload;
		logic [KEY_W-1:0] key;
	} entry_t;

	// Lowest bit first: success, out_key, out_payload, occupancy.
	typedef struct packed {
		logic [OCC_W-1:0] occupancy;
		logic [PAY_W-1:0] out_payload;
		logic [KEY_W-1:0] out_key;
		logic             success;
	} res_t;

endpackage

`default_nettype wire

// ===== sv/keyed_deque_with_removal.sv =====
// keyed_deque_with_removal: bounded deque of key/payload entries with delete by key.
// Entries live in one synchronous single-write, single-read memory; uses kdq_pkg.
// One result transaction per input transaction.
`default_nettype none

// A user of this block sends one operation per input transaction (kind on s_tuser) and gets
// one result transaction back. Pushes at tail or head finish in the cycle they are accepted;
// a pop reads the head slot and finishes in ST_POP from the registered read port of the entry
// memory. A delete streams through the memory one entry per cycle: it reads entries from the
// head until the first matching key, then keeps reading the later entries and writes each one
// slot toward the head, so every held entry is read once. The entry memory has a single port
// pair (one read, one write per cycle). A new transaction is taken as soon as the controller
// is idle, even while a finished result still waits on the output register.
// Key zero never enters the deque and never matches a delete.
module keyed_deque_with_removal #(
	parameter int DEPTH = 128
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// s_tdata: entry_key [63:0], entry_payload [127:64]
	input  wire logic [kdq_pkg::IN_DATA_W-1:0]   s_tdata,
	// s_tuser: kind [1:0]
	input  wire logic [kdq_pkg::KIND_W-1:0]      s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// m_tdata: success [0], out_key [64:1], out_payload [128:65], occupancy [136:129], zeros
	output logic [kdq_pkg::OUT_DATA_W-1:0]       m_tdata
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	// Entry memory and its registered read port
	kdq_pkg::entry_t mem_q [DEPTH];
	kdq_pkg::entry_t mem_rd_s1;

	logic            mem_we;
	logic [IW-1:0]   mem_wa;
	kdq_pkg::entry_t mem_wd;
	logic            mem_re;
	logic [IW-1:0]   mem_ra;

	kdq_pkg::state_t state_q, state_d;
	logic [IW-1:0]   head_q, head_d;
	logic [CW-1:0]   count_q, count_d;
	logic [CW-1:0]   pos_q, pos_d;
	logic [CW-1:0]   pos_s1, pos_s1_d;
	logic            rd_vld_s1, rd_vld_d;
	logic [kdq_pkg::KEY_W-1:0] key_q, key_d;
	kdq_pkg::res_t   res_q, res_d;
	kdq_pkg::res_t   m_res_q, m_res_d;
	logic            m_vld_q, m_vld_d;

	logic            fin;
	kdq_pkg::res_t   fin_res;
	logic            out_free;
	kdq_pkg::kind_t  in_kind;
	logic [kdq_pkg::KEY_W-1:0] in_key;
	logic [kdq_pkg::PAY_W-1:0] in_pay;
	logic            hit;

	// Physical slot of a logical position; head + pos stays below 2 * DEPTH
	function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] h, input logic [CW-1:0] p);
		logic [CW:0] s;
		s = (CW+1)'(h) + (CW+1)'(p);
		if (s >= (CW+1)'(DEPTH)) begin
			s = s - (CW+1)'(DEPTH);
		end
		return s[IW-1:0];
	endfunction

	assign in_kind  = kdq_pkg::kind_t'(s_tuser);
	assign in_key   = s_tdata[kdq_pkg::KEY_W-1:0];
	assign in_pay   = s_tdata[kdq_pkg::IN_DATA_W-1:kdq_pkg::KEY_W];
	assign out_free = !m_vld_q || m_tready;
	assign hit      = rd_vld_s1 && (mem_rd_s1.key == key_q);

	assign m_tvalid = m_vld_q;
	assign m_tdata  = {(kdq_pkg::OUT_DATA_W - $bits(kdq_pkg::res_t))'(0), m_res_q};

	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		count_d  = count_q;
		pos_d    = pos_q;
		pos_s1_d = pos_s1;
		rd_vld_d = 1'b0;
		key_d    = key_q;
		res_d    = res_q;
		m_res_d  = m_res_q;
		m_vld_d  = m_vld_q && !m_tready;
		mem_we   = 1'b0;
		mem_wa   = '0;
		mem_wd   = '0;
		mem_re   = 1'b0;
		mem_ra   = '0;
		fin      = 1'b0;
		fin_res  = '0;
		s_tready = 1'b0;

		unique case (state_q)
			kdq_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					fin_res.occupancy = kdq_pkg::OCC_W'(count_q);
					unique case (in_kind) inside
						kdq_pkg::KIND_PUSH_TAIL, kdq_pkg::KIND_PUSH_HEAD: begin
							fin = 1'b1;
							if (count_q < CW'(DEPTH) && in_key != '0) begin
								mem_we      = 1'b1;
								mem_wd.key  = in_key;
								mem_wd.payload = in_pay;
								if (in_kind == kdq_pkg::KIND_PUSH_TAIL) begin
									mem_wa = slot_of(head_q, count_q);
								end else begin
									head_d = (head_q == '0) ? IW'(DEPTH - 1) : head_q - 1'b1;
									mem_wa = head_d;
								end
								count_d           = count_q + 1'b1;
								fin_res.success   = 1'b1;
								fin_res.occupancy = kdq_pkg::OCC_W'(count_d);
							end
						end
						kdq_pkg::KIND_POP_HEAD: begin
							if (count_q != '0) begin
								mem_re  = 1'b1;
								mem_ra  = head_q;
								state_d = kdq_pkg::ST_POP;
							end else begin
								fin = 1'b1;
							end
						end
						kdq_pkg::KIND_DELETE: begin
							if (count_q != '0 && in_key != '0) begin
								key_d   = in_key;
								pos_d   = '0;
								state_d = kdq_pkg::ST_SCAN;
							end else begin
								fin = 1'b1;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			kdq_pkg::ST_POP: begin
				head_d  = (head_q == IW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
				count_d = count_q - 1'b1;
				fin     = 1'b1;
				fin_res.success     = 1'b1;
				fin_res.out_key     = mem_rd_s1.key;
				fin_res.out_payload = mem_rd_s1.payload;
				fin_res.occupancy   = kdq_pkg::OCC_W'(count_d);
				state_d = kdq_pkg::ST_IDLE;
			end
			kdq_pkg::ST_SCAN: begin
				if (hit) begin
					// capture the removed entry, then close the gap behind it
					res_d.success     = 1'b1;
					res_d.out_key     = mem_rd_s1.key;
					res_d.out_payload = mem_rd_s1.payload;
					res_d.occupancy   = kdq_pkg::OCC_W'(count_q - 1'b1);
					pos_d   = pos_s1 + 1'b1;
					pos_s1_d = pos_s1 + 1'b1;
					state_d = kdq_pkg::ST_SHIFT;
				end else if (pos_q < count_q) begin
					mem_re   = 1'b1;
					mem_ra   = slot_of(head_q, pos_q);
					rd_vld_d = 1'b1;
					pos_s1_d = pos_q;
					pos_d    = pos_q + 1'b1;
				end else begin
					fin = 1'b1;
					fin_res.occupancy = kdq_pkg::OCC_W'(count_q);
					state_d = kdq_pkg::ST_IDLE;
				end
			end
			kdq_pkg::ST_SHIFT: begin
				// move the entry read last cycle one slot toward the head
				if (rd_vld_s1) begin
					mem_we = 1'b1;
					mem_wa = slot_of(head_q, pos_s1 - 1'b1);
					mem_wd = mem_rd_s1;
				end
				if (pos_q < count_q) begin
					mem_re   = 1'b1;
					mem_ra   = slot_of(head_q, pos_q);
					rd_vld_d = 1'b1;
					pos_s1_d = pos_q;
					pos_d    = pos_q + 1'b1;
				end else begin
					count_d = count_q - 1'b1;
					fin     = 1'b1;
					fin_res = res_q;
					state_d = kdq_pkg::ST_IDLE;
				end
			end
			kdq_pkg::ST_EMIT: begin
				if (out_free) begin
					m_vld_d = 1'b1;
					m_res_d = res_q;
					state_d = kdq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = kdq_pkg::ST_IDLE;
			end
		endcase

		// hand the result to the output register, or hold it until that frees up
		if (fin) begin
			if (out_free) begin
				m_vld_d = 1'b1;
				m_res_d = fin_res;
			end else begin
				res_d   = fin_res;
				state_d = kdq_pkg::ST_EMIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= kdq_pkg::ST_IDLE;
			head_q    <= '0;
			count_q   <= '0;
			pos_q     <= '0;
			rd_vld_s1 <= 1'b0;
			m_vld_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			count_q   <= count_d;
			pos_q     <= pos_d;
			rd_vld_s1 <= rd_vld_d;
			m_vld_q   <= m_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_s1  <= pos_s1_d;
		key_q   <= key_d;
		res_q   <= res_d;
		m_res_q <= m_res_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			mem_rd_s1 <= mem_q[mem_ra];
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds depth");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kdq_pkg::ST_SCAN || state_q == kdq_pkg::ST_SHIFT) |-> pos_q <= count_q)
		else $error("scan position beyond occupancy");

	a_no_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> mem_wa != mem_ra)
		else $error("read and write of the same slot in one cycle");

	a_emit_holds_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == kdq_pkg::ST_EMIT |-> m_vld_q)
		else $error("pending result while output register is empty");

	a_shift_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kdq_pkg::ST_SHIFT && pos_q < count_q) |=> count_q == $past(count_q))
		else $error("occupancy changed during compaction");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_keyed_deque_with_removal.sv =====
// tb_keyed_deque_with_removal: self-checking testbench for the keyed deque with delete by key.
// Drives operations on the input stream and checks every result transaction against its own
// deque predictor; depends on kdq_pkg and keyed_deque_with_removal.
`timescale 1ns / 100ps

module tb_keyed_deque_with_removal;

	localparam int DEPTH         = 128;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 300;

	typedef enum {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_t;

	class deque_scoreboard;
		kdq_pkg::entry_t held_q[$];
		kdq_pkg::res_t   expected_q[$];
		int unsigned     errors;

		function new();
			errors = 0;
		endfunction

		function int held();
			return held_q.size();
		endfunction

		function logic [kdq_pkg::KEY_W-1:0] key_at(int idx);
			return held_q[idx].key;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Apply one accepted operation to the shadow deque and queue the result it must give.
		function void note_input(kdq_pkg::kind_t kind, logic [kdq_pkg::KEY_W-1:0] key,
				logic [kdq_pkg::PAY_W-1:0] pay);
			kdq_pkg::res_t   r;
			kdq_pkg::entry_t e;
			int              hit;
			r = '0;
			e.key = key;
			e.payload = pay;
			hit = -1;
			case (kind) inside
				kdq_pkg::KIND_PUSH_TAIL, kdq_pkg::KIND_PUSH_HEAD: begin
					if (held_q.size() < DEPTH && key != '0) begin
						if (kind == kdq_pkg::KIND_PUSH_TAIL)
							held_q.push_back(e);
						else
							held_q.push_front(e);
						r.success = 1'b1;
					end
				end
				kdq_pkg::KIND_POP_HEAD: begin
					if (held_q.size() != 0) begin
						e = held_q.pop_front();
						r.success = 1'b1;
						r.out_key = e.key;
						r.out_payload = e.payload;
					end
				end
				default: begin
					// first match from the head only; key zero never matches
					if (key != '0) begin
						for (int i = 0; i < held_q.size(); i++) begin
							if (hit < 0 && held_q[i].key == key)
								hit = i;
						end
					end
					if (hit >= 0) begin
						e = held_q[hit];
						held_q.delete(hit);
						r.success = 1'b1;
						r.out_key = e.key;
						r.out_payload = e.payload;
					end
				end
			endcase
			r.occupancy = kdq_pkg::OCC_W'(held_q.size());
			expected_q.push_back(r);
		endfunction

		function void check_result(kdq_pkg::res_t got);
			kdq_pkg::res_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.success !== want.success) begin
				$display("%0t: success expected %0d actual %0d", $time, want.success,
					got.success);
				errors++;
			end
			if (got.out_key !== want.out_key) begin
				$display("%0t: out_key expected %h actual %h", $time, want.out_key, got.out_key);
				errors++;
			end
			if (got.out_payload !== want.out_payload) begin
				$display("%0t: out_payload expected %h actual %h", $time, want.out_payload,
					got.out_payload);
				errors++;
			end
			if (got.occupancy !== want.occupancy) begin
				$display("%0t: occupancy expected %0d actual %0d", $time, want.occupancy,
					got.occupancy);
				errors++;
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [kdq_pkg::IN_DATA_W-1:0]  s_tdata;
	logic [kdq_pkg::KIND_W-1:0]     s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [kdq_pkg::OUT_DATA_W-1:0] m_tdata;

	deque_scoreboard sb;
	bit              calm;
	int unsigned     quiet_cycles;

	keyed_deque_with_removal #(
		.DEPTH(DEPTH)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, 8);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Present one operation and hold it until the block takes the transaction.
	task automatic send_op(kdq_pkg::kind_t kind, logic [kdq_pkg::KEY_W-1:0] key,
			logic [kdq_pkg::PAY_W-1:0] pay);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {pay, key};
		s_tuser  <= kind;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_input(kind, key, pay);
	endtask

	// Hold the input side until every expected result has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic kdq_pkg::kind_t pick_kind(mix_t mix);
		int r;
		int t_tail;
		int t_head;
		int t_pop;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL:     begin t_tail = 50; t_head = 90; t_pop = 95; end
			MIX_BALANCED: begin t_tail = 30; t_head = 50; t_pop = 75; end
			default:      begin t_tail = 5;  t_head = 10; t_pop = 55; end
		endcase
		if (r < t_tail)
			return kdq_pkg::KIND_PUSH_TAIL;
		else if (r < t_head)
			return kdq_pkg::KIND_PUSH_HEAD;
		else if (r < t_pop)
			return kdq_pkg::KIND_POP_HEAD;
		return kdq_pkg::KIND_DELETE;
	endfunction

	task automatic run_mix(mix_t mix, int count);
		kdq_pkg::kind_t            kind;
		logic [kdq_pkg::KEY_W-1:0] key;
		logic [kdq_pkg::PAY_W-1:0] pay;
		int                        r;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 39) == 0)
				calm = !calm;
			kind = pick_kind(mix);
			r = $urandom_range(0, 99);
			pay = ($urandom_range(0, 19) == 0) ?
				{kdq_pkg::PAY_W{$urandom_range(0, 1) == 1}} : rand64();
			if (kind == kdq_pkg::KIND_DELETE) begin
				// mostly target a live key so the compaction path gets exercised
				if (r < 70 && sb.held() != 0)
					key = sb.key_at($urandom_range(0, sb.held() - 1));
				else if (r < 82)
					key = kdq_pkg::KEY_W'($urandom_range(1, 16));
				else if (r < 87)
					key = '0;
				else
					key = rand64();
			end else if (r < 3) begin
				key = '0;
			end else if (r < 6) begin
				key = '1;
			end else if (r < 20) begin
				key = kdq_pkg::KEY_W'($urandom_range(1, 16));
			end else begin
				key = rand64();
			end
			send_op(kind, key, pay);
		end
	endtask

	initial begin
		sb = new();
		calm = 1'b0;
		arst_n   = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= kdq_pkg::KIND_PUSH_TAIL;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty cases, extremes, refused key zero, middle and duplicate deletes
		send_op(kdq_pkg::KIND_POP_HEAD, rand64(), rand64());
		send_op(kdq_pkg::KIND_DELETE, 64'd5, '0);
		send_op(kdq_pkg::KIND_PUSH_TAIL, '1, '1);
		send_op(kdq_pkg::KIND_PUSH_HEAD, 64'd1, '0);
		send_op(kdq_pkg::KIND_PUSH_TAIL, '0, 64'h1234);
		send_op(kdq_pkg::KIND_PUSH_TAIL, {32{2'b01}}, {32{2'b10}});
		send_op(kdq_pkg::KIND_PUSH_HEAD, {32{2'b10}}, {32{2'b01}});
		send_op(kdq_pkg::KIND_DELETE, '0, '0);
		send_op(kdq_pkg::KIND_DELETE, '1, rand64());
		send_op(kdq_pkg::KIND_DELETE, 64'd77, '0);
		send_op(kdq_pkg::KIND_PUSH_TAIL, 64'd1, 64'd2);
		send_op(kdq_pkg::KIND_DELETE, 64'd1, '0);
		send_op(kdq_pkg::KIND_DELETE, 64'd1, '0);
		send_op(kdq_pkg::KIND_POP_HEAD, '1, '1);
		send_op(kdq_pkg::KIND_POP_HEAD, '0, '0);
		send_op(kdq_pkg::KIND_POP_HEAD, rand64(), rand64());
		send_op(kdq_pkg::KIND_PUSH_HEAD, 64'h8000_0000_0000_0000, 64'd1);
		send_op(kdq_pkg::KIND_PUSH_TAIL, 64'd9, 64'h8000_0000_0000_0000);
		send_op(kdq_pkg::KIND_DELETE, 64'd9, '0);
		send_op(kdq_pkg::KIND_DELETE, 64'h8000_0000_0000_0000, '0);
		drain_results();

		run_mix(MIX_FILL, 180);
		drain_results();
		run_mix(MIX_BALANCED, 90);
		run_mix(MIX_DRAIN, 180);
		drain_results();
		run_mix(MIX_FILL, 120);
		run_mix(MIX_BALANCED, 80);

		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Result side: random back-pressure, check each result transaction as it is taken.
	initial begin
		int stall;
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			sb.check_result(kdq_pkg::res_t'(m_tdata[$bits(kdq_pkg::res_t)-1:0]));
		end
	end

	// End the run if no transaction moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
